// ----- design/fpba_pkg.sv -----
// Shared constants, codes and helpers of the fit-policy partition allocator.
package fpba_pkg;

	localparam int MAX_PARTITIONS = 32;
	localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);

	localparam int FUNC_W = 2;
	localparam int SLOT_W = 5;
	localparam int AMT_W  = 32;
	localparam int REQN_W = 16;
	localparam int MODE_W = 2;
	localparam int PIU_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// word layouts
	localparam int IN_DATA_W  = 40;	// slot, amount, pad
	localparam int OUT_DATA_W = 88;	// request_number, chosen_slot, chosen_size, leftover, pad

	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIU      = 1'd1;

	localparam logic [PIU_W-1:0] PIU_RESET = 6'd32;

	// search length: partitions_in_use clamped to the table depth
	function automatic logic [CNT_W-1:0] clamp_len(input logic [PIU_W-1:0] piu);
		logic [CNT_W-1:0] res;
		if (32'(piu) > 32'(MAX_PARTITIONS))
			res = CNT_W'(MAX_PARTITIONS);
		else
			res = CNT_W'(piu);
		return res;
	endfunction

endpackage

// ----- design/fpba_size_ram.sv -----
// Partition size store: one write port, one read port with registered data.
module fpba_size_ram (
	input  logic clk,
	input  logic we,
	input  logic [fpba_pkg::IDX_W-1:0] waddr,
	input  logic [fpba_pkg::AMT_W-1:0] wdata,
	input  logic [fpba_pkg::IDX_W-1:0] raddr,
	output logic [fpba_pkg::AMT_W-1:0] rdata
);
	import fpba_pkg::*;

	logic [AMT_W-1:0] mem [MAX_PARTITIONS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- design/fit_policy_block_allocator_top.sv -----
// Top level of the fit-policy partition allocator: control, scan and result register.
//
// Fixed-partition allocator. Sizes live in a 32-entry synchronous RAM, used marks in
// flip-flops cleared by reset. A word on the slave side carries func in tuser: a load
// writes one size and a clear drops every used mark and the request counter. A request
// walks the first partitions_in_use entries, clamped to the table depth, one RAM read
// per cycle (read data registered), keeps the best candidate for fit_mode (first,
// smallest, largest, the spare code acting as first; ties to the lowest index), then
// marks any pick used and posts one result word. The result word is posted once the
// output register is free, and the slave side opens in the same cycle; the scan length
// is set by the single RAM read port and its registered read. Only one word is in work
// at a time; the result sits in an output register so the next word is taken while it
// waits on the master side.
// Sizes never loaded read as anything. No clearing pass after reset.
module fit_policy_block_allocator_top (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
	// slave side
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [fpba_pkg::IN_DATA_W-1:0] s_axis_tdata,	// slot[4:0], amount[36:5]
	input  logic [fpba_pkg::FUNC_W-1:0] s_axis_tuser,	// func[1:0]
	// master side
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// request_number[15:0], chosen_slot[20:16], chosen_size[52:21], leftover[84:53]
	output logic [fpba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tuser	// granted
);
	import fpba_pkg::*;

	localparam int OUT_PAD_W = OUT_DATA_W - REQN_W - SLOT_W - 2 * AMT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t state_q;

	logic [MODE_W-1:0] fit_mode_q;
	logic [PIU_W-1:0]  piu_q;

	logic [MAX_PARTITIONS-1:0] used_q;
	logic [REQN_W-1:0] req_cnt_q;

	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [AMT_W-1:0] amount_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] pick_q;
	logic [AMT_W-1:0] pick_size_q;

	logic m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic m_user_q;

	// input word fields
	logic [FUNC_W-1:0] in_func;
	logic [SLOT_W-1:0] in_slot;
	logic [AMT_W-1:0]  in_amount;
	logic              in_acc;

	assign in_func   = s_axis_tuser;
	assign in_slot   = s_axis_tdata[SLOT_W-1:0];
	assign in_amount = s_axis_tdata[SLOT_W +: AMT_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// size RAM
	logic             ram_we;
	logic [AMT_W-1:0] ram_rdata;
	logic             rd_en;
	logic             fits;
	logic             take;
	logic             out_free;

	assign ram_we = in_acc && (in_func == FUNC_LOAD) && (32'(in_slot) < 32'(MAX_PARTITIONS));
	assign rd_en  = (state_q == ST_SCAN) && (rd_idx_q < len_q);

	fpba_size_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(in_slot)),
		.wdata (in_amount),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// candidate test on the word just read
	assign fits = valid_s1 && !used_q[idx_s1] && (ram_rdata >= amount_q);

	always_comb begin
		take = 1'b0;
		if (fits) begin
			priority if (!found_q)
				take = 1'b1;
			else if (fit_mode_q == MODE_BEST)
				take = ram_rdata < pick_size_q;
			else if (fit_mode_q == MODE_WORST)
				take = ram_rdata > pick_size_q;
			else
				take = 1'b0;	// first fit keeps the earliest hit
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fit_mode_q  <= MODE_FIRST;
			piu_q       <= PIU_RESET;
			used_q      <= '0;
			req_cnt_q   <= '0;
			len_q       <= '0;
			rd_idx_q    <= '0;
			amount_q    <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			pick_size_q <= '0;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
			m_user_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIT_MODE: fit_mode_q <= cfg_data[MODE_W-1:0];
					CFG_PIU:      piu_q      <= cfg_data[PIU_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;

			valid_s1 <= rd_en;
			idx_s1   <= rd_idx_q[IDX_W-1:0];

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						priority if (in_func == FUNC_CLEAR) begin
							used_q    <= '0;
							req_cnt_q <= '0;
						end else if (in_func == FUNC_REQUEST) begin
							len_q    <= clamp_len(piu_q);
							rd_idx_q <= '0;
							amount_q <= in_amount;
							found_q  <= 1'b0;
							pick_q   <= '0;
							state_q  <= ST_SCAN;
						end else begin
							// load is written by the RAM port; unknown func is dropped
						end
					end
				end
				ST_SCAN: begin
					if (rd_en)
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					if (take) begin
						found_q     <= 1'b1;
						pick_q      <= idx_s1;
						pick_size_q <= ram_rdata;
					end
					if (!rd_en && !valid_s1)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_user_q <= found_q;
						if (found_q) begin
							used_q[pick_q] <= 1'b1;
							m_data_q <= {{OUT_PAD_W{1'b0}}, pick_size_q - amount_q,
								pick_size_q, SLOT_W'(pick_q), req_cnt_q};
						end else begin
							m_data_q <= {{(OUT_DATA_W - REQN_W){1'b0}}, req_cnt_q};
						end
						req_cnt_q <= req_cnt_q + REQN_W'(1);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ----- design/fpba_checker.sv -----
// Port-level checks for the fit-policy partition allocator, bound to the top level.
module fpba_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [fpba_pkg::FUNC_W-1:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [fpba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic m_axis_tuser
);
	import fpba_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result word changed under stall");

	// a refused request reports no slot, size or fragment
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_DATA_W-1:REQN_W] == '0)
		else $error("refused request carries a partition");

	// fragment never exceeds the partition size
	a_leftover: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[REQN_W+SLOT_W+AMT_W +: AMT_W] <= m_axis_tdata[REQN_W+SLOT_W +: AMT_W])
		else $error("leftover larger than chosen size");

	// a request holds off the slave side while it scans
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_REQUEST |=> !s_axis_tready)
		else $error("word taken during a scan");

endmodule

bind fit_policy_block_allocator_top fpba_checker u_fpba_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the fit-policy partition allocator top level.
`timescale 1ns / 1ps

module testbench;
	import fpba_pkg::*;

	// func and mode codes that the package leaves unnamed
	localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	// settle wait covers the longest request, with some slack
	localparam int SETTLE_CYCLES = 40;
	localparam int SHOWN_FAULTS = 100;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] slot;
		logic [AMT_W-1:0]  amount;
	} word_t;

	typedef struct packed {
		logic              granted;
		logic [REQN_W-1:0] number;
		logic [SLOT_W-1:0] slot;
		logic [AMT_W-1:0]  size;
		logic [AMT_W-1:0]  leftover;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;	// slot[4:0], amount[36:5]
	logic [FUNC_W-1:0] s_axis_tuser = '0;	// func[1:0]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// request_number[15:0], chosen_slot[20:16], chosen_size[52:21], leftover[84:53]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;	// granted

	fit_policy_block_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #2 clk = ~clk;

	// shadow copy of the allocator: table, marks, counter and registers
	logic [AMT_W-1:0]          part_size [MAX_PARTITIONS];
	logic [MAX_PARTITIONS-1:0] part_used = '0;
	logic [REQN_W-1:0]         reqs_since_clear = '0;
	logic [MODE_W-1:0]         mode_shadow = MODE_FIRST;
	logic [PIU_W-1:0]          piu_shadow = PIU_RESET;

	word_t  word_queue[$];	// words still to be offered on the slave side
	grant_t due_grants[$];	// results owed by the block, oldest first
	word_t  on_bus;
	int     words_issued = 0;
	int     words_taken = 0;
	int     faults = 0;
	logic   steady = 1'b0;	// set: neither side inserts gaps

	// Runs one accepted word through the shadow allocator; a request owes a result.
	function automatic void apply_to_shadow(input word_t w);
		grant_t g;
		int     n;
		int     pick;
		logic   hit;
		g = '0;
		pick = 0;
		hit = 1'b0;
		case (w.func)
		FUNC_LOAD: begin
			part_size[w.slot] = w.amount;	// used mark left alone
		end
		FUNC_CLEAR: begin
			part_used = '0;
			reqs_since_clear = '0;
		end
		FUNC_REQUEST: begin
			n = (int'(piu_shadow) > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(piu_shadow);
			for (int j = 0; j < n; j++) begin
				if (!part_used[j] && part_size[j] >= w.amount) begin
					if (!hit) begin
						hit = 1'b1;
						pick = j;
						// first fit, and the spare mode acting as first fit
						if (mode_shadow != MODE_BEST && mode_shadow != MODE_WORST)
							break;
					end else if (mode_shadow == MODE_BEST && part_size[j] < part_size[pick]) begin
						pick = j;
					end else if (mode_shadow == MODE_WORST && part_size[j] > part_size[pick]) begin
						pick = j;
					end
				end
			end
			g.granted = hit;
			g.number = reqs_since_clear;
			if (hit) begin
				part_used[pick] = 1'b1;
				g.slot = SLOT_W'(pick);
				g.size = part_size[pick];
				g.leftover = part_size[pick] - w.amount;
			end
			reqs_since_clear = reqs_since_clear + 1'b1;	// wraps at 16 bits
			due_grants.push_back(g);
		end
		default: ;	// unknown func: ignored
		endcase
	endfunction

	function automatic void compare_field(input string what, input logic [AMT_W-1:0] want,
			input logic [AMT_W-1:0] got);
		if (want !== got) begin
			faults++;
			if (faults <= SHOWN_FAULTS)
				$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			else if (faults == SHOWN_FAULTS + 1)
				$display("%0t ns: further mismatches not shown", $time);
		end
	endfunction

	// slave side: offers queued words, feeds every accepted one to the shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_to_shadow(on_bus);
				words_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (word_queue.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
					on_bus = word_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {3'b000, on_bus.amount, on_bus.slot};
					s_axis_tuser <= on_bus.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// master side: random back-pressure, each result word checked against the oldest owed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_grants.size() == 0) begin
					faults++;
					if (faults <= SHOWN_FAULTS)
						$display("%0t ns: result with none expected, expected nothing actual %0h_%0h",
							$time, m_axis_tuser, m_axis_tdata);
				end else begin
					grant_t want;
					want = due_grants.pop_front();
					compare_field("granted", AMT_W'(want.granted), AMT_W'(m_axis_tuser));
					compare_field("request_number", AMT_W'(want.number), AMT_W'(m_axis_tdata[15:0]));
					compare_field("chosen_slot", AMT_W'(want.slot), AMT_W'(m_axis_tdata[20:16]));
					compare_field("chosen_size", want.size, m_axis_tdata[52:21]);
					compare_field("leftover", want.leftover, m_axis_tdata[84:53]);
				end
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 14);
		end
	end

	task automatic push_word(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
			input logic [AMT_W-1:0] amount);
		word_t w;
		w.func = func;
		w.slot = slot;
		w.amount = amount;
		word_queue.push_back(w);
		words_issued++;
	endtask

	// partition sizes: a few common values give ties, small ones give near misses
	function automatic logic [AMT_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			case ($urandom_range(4))
			0: return 32'd16;
			1: return 32'd32;
			2: return 32'd64;
			3: return 32'd100;
			default: return 32'd128;
			endcase
		end else if (r < 60) begin
			return AMT_W'($urandom_range(1023));
		end
		return $urandom();
	endfunction

	// request sizes mostly aimed at what the table holds
	function automatic logic [AMT_W-1:0] pick_request();
		logic [AMT_W-1:0] base;
		int r;
		base = part_size[$urandom_range(MAX_PARTITIONS - 1)];
		r = $urandom_range(99);
		if (r < 15)
			return base;
		else if (r < 30)
			return (base != 0) ? base - 1'b1 : base;
		else if (r < 40)
			return base + 1'b1;
		else if (r < 60)
			return AMT_W'($urandom_range(255));
		else if (r < 75)
			return '0;
		return $urandom();
	endfunction

	// pass traffic: mostly requests, some reloads, an occasional clear, a rare ignored func
	task automatic fill_random(input int items);
		int done;
		int r;
		done = 0;
		while (done < items) begin
			r = $urandom_range(99);
			if (r < 2) begin
				// ignored func, does not count
				push_word(FUNC_NOP, SLOT_W'($urandom()), $urandom());
			end else begin
				if (r < 78)
					push_word(FUNC_REQUEST, SLOT_W'($urandom()), pick_request());
				else if (r < 93)
					push_word(FUNC_LOAD, SLOT_W'($urandom()), pick_size());
				else
					push_word(FUNC_CLEAR, SLOT_W'($urandom()), $urandom());
				done++;
			end
		end
	endtask

	// block idle: every word taken, every result in, then the longest scan time
	task automatic settle();
		while (words_taken != words_issued || due_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FIT_MODE)
			mode_shadow = val[MODE_W-1:0];
		else
			piu_shadow = val[PIU_W-1:0];
	endtask

	task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [PIU_W-1:0] piu,
			input int items, input logic calm);
		settle();
		write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_PIU, piu);
		steady = calm;
		fill_random(items);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// whole table loaded first so no search meets an unwritten size
		push_word(FUNC_LOAD, 5'd0, 32'd0);
		for (int s = 1; s < MAX_PARTITIONS - 1; s++)
			push_word(FUNC_LOAD, SLOT_W'(s), pick_size());
		push_word(FUNC_LOAD, 5'd31, 32'hFFFF_FFFF);

		// directed, reset registers (first fit over all 32)
		push_word(FUNC_REQUEST, 5'd0, 32'd0);	// zero request takes the zero-sized slot
		push_word(FUNC_REQUEST, 5'd31, 32'hFFFF_FFFF);	// only the top slot fits
		push_word(FUNC_REQUEST, 5'd0, 32'hFFFF_FFFF);	// nothing left that fits
		push_word(FUNC_NOP, 5'd31, 32'd123);
		push_word(FUNC_LOAD, 5'd0, 32'd7);	// reload of a used slot keeps its mark
		push_word(FUNC_REQUEST, 5'd0, 32'd7);
		push_word(FUNC_CLEAR, 5'd0, 32'd0);
		push_word(FUNC_REQUEST, 5'd0, 32'd7);	// counter back at zero, slot 0 free again
		push_word(FUNC_REQUEST, 5'd31, 32'd1);
		push_word(FUNC_LOAD, 5'd31, 32'hFFFF_FFFF);
		push_word(FUNC_REQUEST, 5'd31, 32'hFFFF_FFFE);
		push_word(FUNC_CLEAR, 5'd31, 32'hFFFF_FFFF);

		run_phase(MODE_FIRST, 6'd32, 150, 1'b0);
		run_phase(MODE_BEST, 6'd32, 150, 1'b0);
		run_phase(MODE_WORST, 6'd32, 150, 1'b1);	// no gaps on either side here
		run_phase(MODE_SPARE, 6'd32, 150, 1'b0);
		run_phase(MODE_BEST, 6'd1, 120, 1'b0);
		run_phase(MODE_WORST, 6'd17, 150, 1'b0);
		run_phase(MODE_FIRST, 6'd33, 150, 1'b0);
		run_phase(MODE_WORST, 6'd63, 150, 1'b0);
		run_phase(MODE_BEST, 6'd8, 150, 1'b0);
		run_phase(MODE_FIRST, 6'd0, 40, 1'b0);	// empty search, every request refused

		run_phase(MODE_BEST, 6'd32, 60, 1'b0);

		settle();
		if (faults == 0)
			$display("[fit_policy_block_allocator_top] OK");
		else
			$display("[fit_policy_block_allocator_top] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[fit_policy_block_allocator_top] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/fpba_pkg.sv
design/fpba_size_ram.sv
design/fit_policy_block_allocator_top.sv
design/fpba_checker.sv
tb/testbench.sv
